// ===== design/sphere_pair_collision_response_defines.svh =====
// assertion macros for the sphere pair collision response block
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef SPHERE_PAIR_COLLISION_RESPONSE_DEFINES_SVH
`define SPHERE_PAIR_COLLISION_RESPONSE_DEFINES_SVH

// property must hold at every clock edge out of reset
`define SPCR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// expression must never be true out of reset
`define SPCR_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

// ===== design/spcr_pkg.sv =====
// shared types, widths and output saturation for the sphere pair collision response
// no dependencies
package spcr_pkg;

  localparam int unsigned LIMB_W     = 32;
  localparam int unsigned Q_W        = 32;
  localparam int unsigned SQ_W       = 64;
  localparam int unsigned SQRT_STEPS = SQ_W / 2;
  localparam int unsigned LEN_W      = SQ_W / 2;

  typedef struct packed {
    logic signed [31:0] dist_x;
    logic signed [31:0] dist_y;
    logic signed [31:0] dist_z;
    logic signed [31:0] rel_vel_x;
    logic signed [31:0] rel_vel_y;
    logic signed [31:0] rel_vel_z;
    logic [30:0]        mass_a;
    logic [30:0]        mass_b;
    logic [30:0]        reach_a;
    logic [30:0]        reach_b;
  } in_t;

  typedef struct packed {
    logic signed [31:0] dvel_a_x;
    logic signed [31:0] dvel_a_y;
    logic signed [31:0] dvel_a_z;
    logic signed [31:0] dvel_b_x;
    logic signed [31:0] dvel_b_y;
    logic signed [31:0] dvel_b_z;
    logic signed [31:0] push_x;
    logic signed [31:0] push_y;
    logic signed [31:0] push_z;
    logic               contact;
    logic               degenerate;
  } out_t;

  // apply sign to a truncated magnitude and clamp to the signed 32 bit range
  function automatic logic signed [31:0] sat32(input logic [Q_W-1:0] q, input logic ovf,
                                              input logic neg);
    logic [31:0] lim;
    logic [31:0] mag;
    lim = neg ? 32'h8000_0000 : 32'h7fff_ffff;
    mag = (ovf || (32'(q) > lim)) ? lim : 32'(q);
    return neg ? $signed(32'(-mag)) : $signed(mag);
  endfunction

endpackage

// ===== design/spcr_dly.sv =====
// fixed delay line with enable, used to carry side data beside the arithmetic units
// no dependencies
module spcr_dly #(
  parameter int unsigned W     = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] pipe_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DEPTH; k++) pipe_q[k] <= '0;
    end else if (en_i) begin
      pipe_q[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) pipe_q[k] <= pipe_q[k-1];
    end
  end

  assign q_o = pipe_q[DEPTH-1];

endmodule

// ===== design/spcr_mul.sv =====
// one stage unsigned multiplier, wide operand split into 32 bit limbs
// depends on spcr_pkg
module spcr_mul #(
  parameter int unsigned A_W = 64,
  parameter int unsigned B_W = 32
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output logic [A_W+B_W-1:0] p_o
);
  import spcr_pkg::*;

  localparam int unsigned NA   = (A_W + LIMB_W - 1) / LIMB_W;
  localparam int unsigned AX_W = NA * LIMB_W;
  localparam int unsigned P_W  = AX_W + LIMB_W;
  localparam int unsigned PP_W = 2 * LIMB_W;

  logic [AX_W-1:0]    a_ext;
  logic [LIMB_W-1:0]  b_ext;
  logic [PP_W-1:0]    pp [NA];
  logic [P_W-1:0]     acc;
  logic [A_W+B_W-1:0] p_q;

  always_comb begin
    a_ext = AX_W'(a_i);
    b_ext = LIMB_W'(b_i);
    acc   = '0;
    for (int k = 0; k < NA; k++) begin
      pp[k] = PP_W'(a_ext[k*LIMB_W +: LIMB_W]) * PP_W'(b_ext);
      acc   = acc + (P_W'(pp[k]) << (k * LIMB_W));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) p_q <= acc[A_W+B_W-1:0];
  end

  assign p_o = p_q;

endmodule

// ===== design/spcr_isqrt.sv =====
// pipelined integer square root, one result bit per stage
// depends on spcr_pkg
module spcr_isqrt (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [spcr_pkg::SQ_W-1:0]  s_i,
  output logic [spcr_pkg::LEN_W-1:0] len_o
);
  import spcr_pkg::*;

  logic [SQ_W-1:0] s_q [SQRT_STEPS];
  logic [SQ_W-1:0] r_q [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * j);
    logic [SQ_W-1:0] s_in;
    logic [SQ_W-1:0] r_in;
    logic [SQ_W:0]   trial;
    logic            ge;

    if (j == 0) begin : g_first
      assign s_in = s_i;
      assign r_in = '0;
    end else begin : g_next
      assign s_in = s_q[j-1];
      assign r_in = r_q[j-1];
    end

    assign trial = {1'b0, r_in} + {1'b0, BIT};
    assign ge    = {1'b0, s_in} >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[j] <= ge ? (s_in - trial[SQ_W-1:0]) : s_in;
        r_q[j] <= ge ? ((r_in >> 1) + BIT) : (r_in >> 1);
      end
    end
  end

  assign len_o = r_q[SQRT_STEPS-1][LEN_W-1:0];

endmodule

// ===== design/spcr_div.sv =====
// pipelined restoring divider, one quotient bit per stage, flags quotients past 32 bits
// depends on spcr_pkg
module spcr_div #(
  parameter int unsigned N_W = 128,
  parameter int unsigned D_W = 96
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [N_W-1:0]           n_i,
  input  logic [D_W-1:0]           d_i,
  output logic [spcr_pkg::Q_W-1:0] q_o,
  output logic                     ovf_o
);
  import spcr_pkg::*;

  localparam int unsigned C_W = ((N_W > D_W + Q_W) ? N_W : D_W + Q_W) + 1;

  logic [N_W-1:0] rem_q [Q_W];
  logic [D_W-1:0] den_q [Q_W];
  logic [Q_W-1:0] quo_q [Q_W];
  logic           ovf_q [Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_step
    localparam int unsigned SH = Q_W - 1 - j;
    logic [N_W-1:0] rem_in;
    logic [D_W-1:0] den_in;
    logic [Q_W-1:0] quo_in;
    logic           ovf_in;
    logic [C_W-1:0] sub;

    if (j == 0) begin : g_first
      assign rem_in = n_i;
      assign den_in = d_i;
      assign quo_in = '0;
      assign ovf_in = C_W'(n_i) >= (C_W'(d_i) << Q_W);
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
      assign ovf_in = ovf_q[j-1];
    end

    assign sub = C_W'(rem_in) - (C_W'(den_in) << SH);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= sub[C_W-1] ? rem_in : sub[N_W-1:0];
        den_q[j] <= den_in;
        quo_q[j] <= quo_in | (Q_W'(!sub[C_W-1]) << SH);
        ovf_q[j] <= ovf_in;
      end
    end
  end

  assign q_o   = quo_q[Q_W-1];
  assign ovf_o = ovf_q[Q_W-1];

endmodule

// ===== design/sphere_pair_collision_response.sv =====
// top level: elastic response and overlap push for one sphere pair per cycle while the pipe is not stalled
// depends on spcr_pkg, spcr_dly, spcr_mul, spcr_isqrt, spcr_div and the defines header
//
//   channel   signals                          direction
//   request   in_valid_i / in_ready_o / in_i   pair in
//   result    out_valid_o / out_ready_i / out_o response out
//
// one pair accepted per cycle while the pipe is not stalled
// latency is set by the 32 step square root followed by the 32 step push divider
// reset clears the valid bits, the output register valid and every spcr_dly delay line; other registers are not reset
// a stall freezes the whole pipe only when the last stage holds a result and the
// output register is still full; bubbles keep draining otherwise
`include "sphere_pair_collision_response_defines.svh"
module sphere_pair_collision_response (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  spcr_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output spcr_pkg::out_t out_o
);
  import spcr_pkg::*;

  localparam int unsigned ST_LEN  = 2 + SQRT_STEPS;
  localparam int unsigned ST_VQ   = 5 + Q_W;
  localparam int unsigned ST_END  = ST_LEN + 1 + Q_W;

  logic v_end, load, en;
  logic out_valid_q;
  out_t out_q, out_d;

  assign load       = !out_valid_q || out_ready_i;
  assign en         = load || !v_end;
  assign in_ready_o = en;

  spcr_dly #(.W(1), .DEPTH(ST_END)) u_vld (
    .clk_i, .rst_ni, .en_i(en), .d_i(in_valid_i), .q_o(v_end)
  );

  // stage 1
  logic signed [31:0] dvec [3];
  logic signed [31:0] vel [3];
  logic [31:0] ad1_d [3], av1 [3];
  logic [31:0] ad1_q [3], ad2_q [3], ad3_q [3];
  logic [2:0]  dn1_q, dn2_q, dn3_q;
  logic [63:0] sq1_q [3], pm1_q [3];
  logic [2:0]  pn1_q;
  logic [31:0] reach1_q, msum1_q, msum2_q;
  logic [30:0] ma1_q, ma2_q, ma3_q, ma4_q, mb1_q, mb2_q, mb3_q, mb4_q;

  always_comb begin
    dvec[0] = in_i.dist_x;
    dvec[1] = in_i.dist_y;
    dvec[2] = in_i.dist_z;
    vel[0]  = in_i.rel_vel_x;
    vel[1]  = in_i.rel_vel_y;
    vel[2]  = in_i.rel_vel_z;
    for (int i = 0; i < 3; i++) begin
      ad1_d[i] = dvec[i][31] ? 32'(-dvec[i]) : 32'(dvec[i]);
      av1[i]   = vel[i][31] ? 32'(-vel[i]) : 32'(vel[i]);
    end
  end

  // stage 2 and 3
  logic [63:0]        s2_d, s2_q;
  logic signed [65:0] dot2_d, dot2_q;
  logic [65:0]        dabs;
  logic [63:0]        dmag3_q;
  logic               dneg3_q, degen3_q, mz3_q;

  always_comb begin
    s2_d   = sq1_q[0] + sq1_q[1] + sq1_q[2];
    dot2_d = '0;
    for (int i = 0; i < 3; i++) begin
      dot2_d = dot2_d + (pn1_q[i] ? -$signed({2'b00, pm1_q[i]}) : $signed({2'b00, pm1_q[i]}));
    end
    dabs = dot2_q[65] ? 66'(-dot2_q) : 66'(dot2_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ad1_q[i] <= ad1_d[i];
        sq1_q[i] <= 64'(ad1_d[i]) * 64'(ad1_d[i]);
        pm1_q[i] <= 64'(ad1_d[i]) * 64'(av1[i]);
        pn1_q[i] <= dvec[i][31] ^ vel[i][31];
        dn1_q[i] <= dvec[i][31];
        ad2_q[i] <= ad1_q[i];
        ad3_q[i] <= ad2_q[i];
      end
      dn2_q    <= dn1_q;
      dn3_q    <= dn2_q;
      reach1_q <= 32'(in_i.reach_a) + 32'(in_i.reach_b);
      msum1_q  <= 32'(in_i.mass_a) + 32'(in_i.mass_b);
      msum2_q  <= msum1_q;
      ma1_q    <= in_i.mass_a;
      ma2_q    <= ma1_q;
      ma3_q    <= ma2_q;
      ma4_q    <= ma3_q;
      mb1_q    <= in_i.mass_b;
      mb2_q    <= mb1_q;
      mb3_q    <= mb2_q;
      mb4_q    <= mb3_q;
      s2_q     <= s2_d;
      dot2_q   <= dot2_d;
      dmag3_q  <= dabs[63:0];
      dneg3_q  <= dot2_q[65];
      degen3_q <= (s2_q == '0);
      mz3_q    <= (msum2_q == '0);
    end
  end

  // distance and denominator
  logic [LEN_W-1:0] len34;
  logic [95:0]      den3, den5;

  spcr_isqrt u_isqrt (.clk_i, .en_i(en), .s_i(s2_q), .len_o(len34));

  spcr_mul #(.A_W(64), .B_W(32)) u_den (
    .clk_i, .en_i(en), .a_i(s2_q), .b_i(msum2_q), .p_o(den3)
  );

  spcr_dly #(.W(96), .DEPTH(2)) u_den_dly (
    .clk_i, .rst_ni, .en_i(en), .d_i(den3), .q_o(den5)
  );

  // side data to the end of the pipe
  logic [127:0] geo34;
  logic [31:0]  reach34;
  logic [31:0]  ad34 [3];
  logic [2:0]   sg3, sg67, dn67;
  logic         degen67, mz67, contact34, contact67;
  logic [32:0]  dlen35_q;

  assign sg3 = dn3_q ^ {3{dneg3_q}};

  spcr_dly #(.W(128), .DEPTH(ST_LEN - 1)) u_geo_dly (
    .clk_i, .rst_ni, .en_i(en), .d_i({reach1_q, ad1_q[2], ad1_q[1], ad1_q[0]}), .q_o(geo34)
  );

  assign reach34   = geo34[127:96];
  assign ad34[2]   = geo34[95:64];
  assign ad34[1]   = geo34[63:32];
  assign ad34[0]   = geo34[31:0];
  assign contact34 = len34 < reach34;

  spcr_dly #(.W(5), .DEPTH(ST_END - 3)) u_flag_dly (
    .clk_i, .rst_ni, .en_i(en), .d_i({degen3_q, mz3_q, sg3}), .q_o({degen67, mz67, sg67})
  );

  spcr_dly #(.W(3), .DEPTH(ST_END - 1)) u_sign_dly (
    .clk_i, .rst_ni, .en_i(en), .d_i(dn1_q), .q_o(dn67)
  );

  spcr_dly #(.W(1), .DEPTH(ST_END - ST_LEN)) u_contact_dly (
    .clk_i, .rst_ni, .en_i(en), .d_i(contact34), .q_o(contact67)
  );

  always_ff @(posedge clk_i) begin
    if (en) dlen35_q <= {len34, 1'b0};
  end

  // per axis arithmetic
  logic [Q_W-1:0] qa67 [3], qb67 [3], qp67 [3];
  logic           oa67 [3], ob67 [3], op67 [3];

  for (genvar i = 0; i < 3; i++) begin : g_axis
    logic [95:0]    t4;
    logic [127:0]   na5, nb5;
    logic [Q_W-1:0] qa37, qb37;
    logic           oa37, ob37;
    logic [63:0]    pn35;

    spcr_mul #(.A_W(64), .B_W(32)) u_t (
      .clk_i, .en_i(en), .a_i(dmag3_q), .b_i(ad3_q[i]), .p_o(t4)
    );
    spcr_mul #(.A_W(96), .B_W(32)) u_na (
      .clk_i, .en_i(en), .a_i(t4), .b_i({mb4_q, 1'b0}), .p_o(na5)
    );
    spcr_mul #(.A_W(96), .B_W(32)) u_nb (
      .clk_i, .en_i(en), .a_i(t4), .b_i({ma4_q, 1'b0}), .p_o(nb5)
    );
    spcr_div #(.N_W(128), .D_W(96)) u_div_a (
      .clk_i, .en_i(en), .n_i(na5), .d_i(den5), .q_o(qa37), .ovf_o(oa37)
    );
    spcr_div #(.N_W(128), .D_W(96)) u_div_b (
      .clk_i, .en_i(en), .n_i(nb5), .d_i(den5), .q_o(qb37), .ovf_o(ob37)
    );
    spcr_dly #(.W(2 * Q_W + 2), .DEPTH(ST_END - ST_VQ)) u_vel_dly (
      .clk_i, .rst_ni, .en_i(en), .d_i({qa37, oa37, qb37, ob37}),
      .q_o({qa67[i], oa67[i], qb67[i], ob67[i]})
    );

    spcr_mul #(.A_W(32), .B_W(32)) u_pn (
      .clk_i, .en_i(en), .a_i(reach34 - len34), .b_i(ad34[i]), .p_o(pn35)
    );
    spcr_div #(.N_W(64), .D_W(33)) u_div_p (
      .clk_i, .en_i(en), .n_i(pn35), .d_i(dlen35_q), .q_o(qp67[i]), .ovf_o(op67[i])
    );
  end

  // output formatting
  logic contact_ok, vel_ok;
  logic signed [31:0] dva [3], dvb [3], psh [3];

  always_comb begin
    contact_ok = contact67 && !degen67;
    vel_ok     = contact_ok && !mz67;
    for (int i = 0; i < 3; i++) begin
      dva[i] = vel_ok ? sat32(qa67[i], oa67[i], !sg67[i]) : '0;
      dvb[i] = vel_ok ? sat32(qb67[i], ob67[i], sg67[i]) : '0;
      psh[i] = contact_ok ? sat32(qp67[i], op67[i], dn67[i]) : '0;
    end
    out_d.dvel_a_x   = dva[0];
    out_d.dvel_a_y   = dva[1];
    out_d.dvel_a_z   = dva[2];
    out_d.dvel_b_x   = dvb[0];
    out_d.dvel_b_y   = dvb[1];
    out_d.dvel_b_z   = dvb[2];
    out_d.push_x     = psh[0];
    out_d.push_y     = psh[1];
    out_d.push_z     = psh[2];
    out_d.contact    = contact_ok;
    out_d.degenerate = degen67;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= v_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `SPCR_NEVER(a_flag_excl, out_valid_o && out_o.contact && out_o.degenerate,
              "contact with degenerate")
  `SPCR_ASSERT(a_no_contact_zero, out_valid_o && !out_o.contact |->
               out_o.push_x == '0 && out_o.push_y == '0 && out_o.push_z == '0 &&
               out_o.dvel_a_x == '0 && out_o.dvel_b_x == '0,
               "nonzero response without contact")
  `SPCR_ASSERT(a_stall_cause, !in_ready_o |-> out_valid_o && !out_ready_i,
               "input stalled without output backpressure")

endmodule

// ===== sim/tb_sphere_pair_collision_response.sv =====
// testbench for sphere_pair_collision_response: directed, random and backpressure tests
// predicts each response in fixed point and checks results in order
// depends on spcr_pkg and the sphere_pair_collision_response rtl
`timescale 1ns / 1ps
module tb_sphere_pair_collision_response;
  import spcr_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_o;

  out_t responses_due[$];
  int   mismatches;
  int   burst_left;
  bit   hold_req;

  sphere_pair_collision_response dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_i(in_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_o(out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] root_floor(input logic [63:0] sq);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > sq) b = b >> 2;
    while (b != 0) begin
      if (sq >= r + b) begin
        sq = sq - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp_q(input logic [127:0] mag, input logic neg);
    logic [127:0] lim;
    logic [31:0]  m;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    m = (mag > lim) ? lim[31:0] : mag[31:0];
    return neg ? $signed(-m) : $signed(m);
  endfunction

  function automatic out_t predict_response(input in_t p);
    logic signed [31:0] d[3];
    logic signed [31:0] v[3];
    logic [31:0]  ad[3];
    logic [31:0]  av;
    logic [63:0]  sq, len, rch, num, pq;
    logic [127:0] dot, dmag, t, den, prod, pr;
    logic [32:0]  msum;
    logic         dneg, sg;
    logic signed [31:0] res[9];
    out_t r;
    r = '0;
    d[0] = p.dist_x; d[1] = p.dist_y; d[2] = p.dist_z;
    v[0] = p.rel_vel_x; v[1] = p.rel_vel_y; v[2] = p.rel_vel_z;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      ad[i] = d[i] < 0 ? -d[i] : d[i];
      sq = sq + {32'd0, ad[i]} * {32'd0, ad[i]};
      res[i] = 0; res[3+i] = 0; res[6+i] = 0;
    end
    rch = {33'd0, p.reach_a} + {33'd0, p.reach_b};
    if (sq == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    len = root_floor(sq);
    if (len >= rch) return r;
    r.contact = 1'b1;
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      av = v[i] < 0 ? -v[i] : v[i];
      pr = {96'd0, ad[i]} * {96'd0, av};
      if ((d[i] < 0) != (v[i] < 0)) pr = -pr;
      dot = dot + pr;
    end
    dneg = dot[127];
    dmag = dneg ? -dot : dot;
    msum = {2'd0, p.mass_a} + {2'd0, p.mass_b};
    if (msum != 0) begin
      den = {95'd0, msum} * {64'd0, sq};
      for (int i = 0; i < 3; i++) begin
        t = {64'd0, dmag[63:0]} * {96'd0, ad[i]};
        sg = dneg != (d[i] < 0);
        prod = t * {96'd0, p.mass_b, 1'b0};
        res[i] = clamp_q(prod / den, !sg);
        prod = t * {96'd0, p.mass_a, 1'b0};
        res[3+i] = clamp_q(prod / den, sg);
      end
    end
    for (int i = 0; i < 3; i++) begin
      num = (rch - len) * {32'd0, ad[i]};
      pq = num / (len << 1);
      res[6+i] = clamp_q({64'd0, pq}, d[i] < 0);
    end
    r.dvel_a_x = res[0]; r.dvel_a_y = res[1]; r.dvel_a_z = res[2];
    r.dvel_b_x = res[3]; r.dvel_b_y = res[4]; r.dvel_b_z = res[5];
    r.push_x = res[6]; r.push_y = res[7]; r.push_z = res[8];
    return r;
  endfunction

  task automatic compare_field(input string nm, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      mismatches++;
      $display("%0t %s expected %h actual %h", $time, nm, e, a);
    end
  endtask

  // response checker
  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (responses_due.size() == 0) begin
        mismatches++;
        $display("%0t unexpected response actual %h", $time, out_o);
      end else begin
        e = responses_due.pop_front();
        compare_field("dvel_a_x", e.dvel_a_x, out_o.dvel_a_x);
        compare_field("dvel_a_y", e.dvel_a_y, out_o.dvel_a_y);
        compare_field("dvel_a_z", e.dvel_a_z, out_o.dvel_a_z);
        compare_field("dvel_b_x", e.dvel_b_x, out_o.dvel_b_x);
        compare_field("dvel_b_y", e.dvel_b_y, out_o.dvel_b_y);
        compare_field("dvel_b_z", e.dvel_b_z, out_o.dvel_b_z);
        compare_field("push_x", e.push_x, out_o.push_x);
        compare_field("push_y", e.push_y, out_o.push_y);
        compare_field("push_z", e.push_z, out_o.push_z);
        compare_field("contact", 32'(e.contact), 32'(out_o.contact));
        compare_field("degenerate", 32'(e.degenerate), 32'(out_o.degenerate));
      end
    end
  end

  // receiver stall pattern, with a long hold-off on demand
  initial begin
    int mode;
    int left;
    out_ready_i = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (250) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(10, 120);
        end
        left--;
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_pair(input in_t p);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_i <= p;
    do @(posedge clk_i); while (!in_ready_o);
    responses_due.push_back(predict_response(p));
  endtask

  task automatic send_paced(input in_t p);
    send_pair(p);
    if (burst_left == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 40);
    end else begin
      burst_left--;
    end
  endtask

  function automatic in_t random_pair(input bit near);
    in_t p;
    int k;
    int kr;
    p.dist_x = $urandom; p.dist_y = $urandom; p.dist_z = $urandom;
    p.rel_vel_x = $urandom; p.rel_vel_y = $urandom; p.rel_vel_z = $urandom;
    p.mass_a = 31'($urandom >> $urandom_range(1, 31));
    p.mass_b = 31'($urandom >> $urandom_range(1, 31));
    p.reach_a = 31'($urandom);
    p.reach_b = 31'($urandom);
    if (near) begin
      k = $urandom_range(0, 30);
      kr = k > 3 ? k - 3 : 0;
      p.dist_x = p.dist_x >>> k; p.dist_y = p.dist_y >>> k; p.dist_z = p.dist_z >>> k;
      p.reach_a = p.reach_a >> kr;
      p.reach_b = p.reach_b >> kr;
      k = $urandom_range(0, 31);
      p.rel_vel_x = p.rel_vel_x >>> k; p.rel_vel_y = p.rel_vel_y >>> k;
      p.rel_vel_z = p.rel_vel_z >>> k;
    end
    if (p.mass_a == 0) p.mass_a = 1;
    if (p.mass_b == 0) p.mass_b = 1;
    return p;
  endfunction

  function automatic in_t make_pair(input int dx, dy, dz, vx, vy, vz,
                                    input logic [31:0] ma, mb, ra, rb);
    in_t p;
    p.dist_x = dx; p.dist_y = dy; p.dist_z = dz;
    p.rel_vel_x = vx; p.rel_vel_y = vy; p.rel_vel_z = vz;
    p.mass_a = 31'(ma); p.mass_b = 31'(mb); p.reach_a = 31'(ra); p.reach_b = 31'(rb);
    return p;
  endfunction

  task automatic test_directed;
    localparam int ONE = 32'h0001_0000;
    localparam int MINV = 32'h8000_0000;
    localparam int MAXV = 32'h7fff_ffff;
    localparam logic [31:0] MAXU = 32'h7fff_ffff;
    send_paced(make_pair(0, 0, 0, ONE, 0, 0, ONE, ONE, ONE, ONE));
    send_paced(make_pair(0, 0, 0, MINV, MAXV, 0, MAXU, 1, MAXU, MAXU));
    send_paced(make_pair(0, 0, 0, 0, 0, 0, 1, 1, 0, 0));
    send_paced(make_pair(10 * ONE, 0, 0, ONE, 0, 0, ONE, ONE, ONE, ONE));
    send_paced(make_pair(ONE, 0, 0, -ONE, 0, 0, ONE, ONE, ONE, ONE));
    send_paced(make_pair(ONE, ONE, -ONE, -3 * ONE, ONE, 2 * ONE, 2 * ONE, ONE, ONE, ONE));
    send_paced(make_pair(1, 0, 0, MINV, 0, 0, MAXU, 1, 1, 1));
    send_paced(make_pair(-1, 0, 0, MAXV, 0, 0, 1, MAXU, 1, 1));
    send_paced(make_pair(1, 1, 1, MINV, MINV, MINV, MAXU, MAXU, 0, MAXU));
    send_paced(make_pair(MINV, MINV, MINV, MINV, MINV, MINV, MAXU, MAXU, MAXU, MAXU));
    send_paced(make_pair(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 1, 1, MAXU, MAXU));
    send_paced(make_pair(MINV, 0, 0, MAXV, 0, 0, ONE, ONE, MAXU, MAXU));
    send_paced(make_pair(MAXV, MINV, 0, 0, 0, MINV, 1, MAXU, MAXU, MAXU));
    send_paced(make_pair(ONE, 0, 0, 0, 0, 0, ONE, ONE, 32'h8000, 32'h8000));
    send_paced(make_pair(ONE, 0, 0, 0, 0, 0, ONE, ONE, 32'h8000, 32'h8001));
    send_paced(make_pair(0, 3, 4, 0, -5, 0, ONE, 3 * ONE, 3, 3));
    send_paced(make_pair(0, 0, 1, 0, 0, 1, 1, 1, 1, 0));
    send_paced(make_pair(0, -ONE, 0, 0, ONE, 0, MAXU, MAXU, MAXU, 0));
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) send_paced(random_pair($urandom_range(0, 9) < 8));
  endtask

  task automatic test_backpressure;
    hold_req = 1'b1;
    for (int i = 0; i < 150; i++) send_pair(random_pair(1'b1));
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  initial begin
    mismatches = 0;
    burst_left = 0;
    hold_req = 1'b0;
    in_valid_i = 1'b0;
    in_i = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(900);
    test_backpressure();
    test_random(900);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (responses_due.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("sphere_pair_collision_response test passed");
    end else begin
      $display("sphere_pair_collision_response test failed");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("sphere_pair_collision_response test failed");
    $finish;
  end

endmodule

// ===== sphere_pair_collision_response.f =====
+incdir+design
design/spcr_pkg.sv
design/spcr_dly.sv
design/spcr_mul.sv
design/spcr_isqrt.sv
design/spcr_div.sv
design/sphere_pair_collision_response.sv
sim/tb_sphere_pair_collision_response.sv
